[src/cplm_pkg.sv]
`default_nettype none

package cplm_pkg;

    // Block configuration
    localparam int CORES        = 4;
    localparam int MAX_CORES    = 4;
    localparam int PEAK_SAMPLES = 10;

    // Field widths
    localparam int TIME_W = 32;
    localparam int IDLE_W = 64;
    localparam int LOAD_W = 7;
    localparam int NUM_W  = TIME_W + LOAD_W;

    localparam logic [TIME_W-1:0] SAMPLE_PERIOD_RST = TIME_W'(500000);
    localparam logic [LOAD_W-1:0] PCT_SCALE         = LOAD_W'(100);
    localparam logic [2:0]        DIV_LAST_STEP     = 3'(LOAD_W - 1);

    // Peak ring and its running sum; mean by reciprocal multiply
    localparam int POS_W     = (PEAK_SAMPLES > 1) ? $clog2(PEAK_SAMPLES) : 1;
    localparam int SUM_W     = $clog2(PEAK_SAMPLES * 100 + 1);
    localparam int AVG_SHIFT = SUM_W + 7;
    localparam int RECIP_W   = AVG_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** AVG_SHIFT + PEAK_SAMPLES - 1) / PEAK_SAMPLES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PEAK_SAMPLES - 1);

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic [IDLE_W-1:0] idle_core0;
        logic [IDLE_W-1:0] idle_core1;
        logic [IDLE_W-1:0] idle_core2;
        logic [IDLE_W-1:0] idle_core3;
    } t_poll;

    typedef struct packed {
        logic [LOAD_W-1:0] load_core0;
        logic [LOAD_W-1:0] load_core1;
        logic [LOAD_W-1:0] load_core2;
        logic [LOAD_W-1:0] load_core3;
        logic [LOAD_W-1:0] peak_average;
        logic              loads_refreshed;
    } t_result;

    // Sequencer commands shared by all lanes
    typedef struct packed {
        logic       prep;
        logic       mul;
        logic       div;
        logic       sel_peak;
        logic       commit_avg;
        logic       commit_peak;
        logic       refresh;
        logic [2:0] step;
    } t_lane_ctrl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP_A,
        S_MUL_A,
        S_DIV_A,
        S_PREP_P,
        S_MUL_P,
        S_DIV_P,
        S_MERGE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[src/cplm_lane.sv]
`default_nettype none

// One core: interval load = floor(100*busy/T), by 7-step restoring divide.
module cplm_lane
    import cplm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_lane_ctrl  i_ctrl,
    input  wire [TIME_W-1:0] i_avg_elapsed,
    input  wire [TIME_W-1:0] i_peak_elapsed,
    input  wire [IDLE_W-1:0] i_idle,
    output logic [LOAD_W-1:0] o_load,
    output logic [LOAD_W-1:0] o_quot
);

    logic [IDLE_W-1:0] r_mark_avg;
    logic [IDLE_W-1:0] r_mark_peak;
    logic [LOAD_W-1:0] r_load;
    logic [TIME_W-1:0] r_div;
    logic [TIME_W-1:0] r_busy;
    logic              r_zero;
    logic [NUM_W-1:0]  r_rem;
    logic [LOAD_W-1:0] r_quot;

    logic [TIME_W-1:0] elapsed;
    logic [IDLE_W-1:0] mark;
    logic [IDLE_W-1:0] delta;
    logic              is_zero;
    logic [NUM_W-1:0]  div_sh;

    always_comb begin
        elapsed = i_ctrl.sel_peak ? i_peak_elapsed : i_avg_elapsed;
        mark    = i_ctrl.sel_peak ? r_mark_peak : r_mark_avg;
        delta   = i_idle - mark;
        is_zero = (elapsed == '0) || (delta > IDLE_W'(elapsed));
        div_sh  = NUM_W'(r_div) << i_ctrl.step;
    end

    // marks and averaged load are architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_avg  <= '0;
            r_mark_peak <= '0;
            r_load      <= '0;
        end else begin
            if (i_ctrl.commit_avg && i_ctrl.refresh) begin
                r_load     <= r_quot;
                r_mark_avg <= i_idle;
            end
            if (i_ctrl.commit_peak) begin
                r_mark_peak <= i_idle;
            end
        end
    end

    // datapath; a zero-load interval keeps its cleared quotient (divisor may be 0)
    always_ff @(posedge i_clk) begin
        if (i_ctrl.prep) begin
            r_div  <= elapsed;
            r_busy <= elapsed - delta[TIME_W-1:0];
            r_zero <= is_zero;
        end
        if (i_ctrl.mul) begin
            r_rem  <= r_zero ? '0 : NUM_W'(r_busy) * NUM_W'(PCT_SCALE);
            r_quot <= '0;
        end
        if (i_ctrl.div) begin
            if (!r_zero && (r_rem >= div_sh)) begin
                r_rem                <= r_rem - div_sh;
                r_quot[i_ctrl.step]  <= 1'b1;
            end
        end
    end

    assign o_load = r_load;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[src/cplm_merge.sv]
`default_nettype none

// Max over lanes, peak ring with running sum, mean by reciprocal multiply.
module cplm_merge
    import cplm_pkg::*;
(
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_merge_en,
    input  wire [MAX_CORES-1:0][LOAD_W-1:0]   i_peak,
    output logic [LOAD_W-1:0]                 o_peak_average
);

    logic [LOAD_W-1:0] r_ring [PEAK_SAMPLES];
    logic [POS_W-1:0]  r_pos;
    logic [SUM_W-1:0]  r_sum;

    logic [LOAD_W-1:0] peak;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] prod;

    always_comb begin
        peak = '0;
        for (int i = 0; i < MAX_CORES; i++) begin
            if (i_peak[i] > peak) begin
                peak = i_peak[i];
            end
        end
        n_sum = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(peak);
        prod  = PROD_W'(r_sum) * PROD_W'(AVG_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEAK_SAMPLES; i++) begin
                r_ring[i] <= '0;
            end
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_merge_en) begin
            r_ring[r_pos] <= peak;
            r_sum         <= n_sum;
            r_pos         <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        end
    end

    assign o_peak_average = prod[AVG_SHIFT +: LOAD_W];

endmodule

`default_nettype wire

[src/cpu_load_peak_monitor_unit.sv]
`default_nettype none

// CPU load and peak-load monitor. Each input beat is one poll: a wrapping
// microsecond timestamp and four cumulative per-core idle counters. Every
// poll yields exactly one output beat with the averaged per-core loads
// (refreshed only once sample_period microseconds have passed since the
// last refresh; loads_refreshed flags it) and the truncated mean of a
// ring of the last PEAK_SAMPLES per-poll peak core loads (cleared at
// reset). Loads are floor(100*(T-d)/T), 0 when T is zero or the idle
// delta exceeds T. A poll occupies the block from its accept beat until
// its result enters the output register (o_in_stall is high meanwhile):
// each core lane owns one multiply-and-divide unit that produces 7
// quotient bits, one per cycle, and runs twice per poll (averaged load,
// then peak load), followed by a merge step and an output step. A finished
// result sits in the output register, so a new poll is taken while it
// waits. sample_period is written through the cfg beat port (always
// ready, reset value 500000) and must only change while no poll is in
// flight.
module cpu_load_peak_monitor_unit
    import cplm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // poll channel
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire t_poll       i_in_data,
    // result channel
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_result          o_out_data,
    // sample_period write port
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [TIME_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [2:0]        r_step;
    t_poll             r_in;
    logic [TIME_W-1:0] r_avg_el;
    logic [TIME_W-1:0] r_peak_el;
    logic              r_refresh;
    logic [TIME_W-1:0] r_time_mark_avg;
    logic [TIME_W-1:0] r_time_mark_peak;
    logic [TIME_W-1:0] r_sample_period;
    t_result           r_out;
    logic              r_out_valid;

    logic              in_accept;
    logic              out_load;
    logic [TIME_W-1:0] avg_el;
    t_lane_ctrl        lane_ctrl;
    logic              merge_en;
    t_result           n_out;

    logic [MAX_CORES-1:0][IDLE_W-1:0] idle;
    logic [MAX_CORES-1:0][LOAD_W-1:0] lane_load;
    logic [MAX_CORES-1:0][LOAD_W-1:0] lane_quot;
    logic [LOAD_W-1:0]                peak_average;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    // result register frees up when empty or being taken this cycle
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign avg_el      = i_in_data.time_now - r_time_mark_avg;

    assign idle[0] = r_in.idle_core0;
    assign idle[1] = r_in.idle_core1;
    assign idle[2] = r_in.idle_core2;
    assign idle[3] = r_in.idle_core3;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_accept) n_state = S_PREP_A;
            S_PREP_A: n_state = S_MUL_A;
            S_MUL_A:  n_state = S_DIV_A;
            S_DIV_A:  if (r_step == '0) n_state = S_PREP_P;
            S_PREP_P: n_state = S_MUL_P;
            S_MUL_P:  n_state = S_DIV_P;
            S_DIV_P:  if (r_step == '0) n_state = S_MERGE;
            S_MERGE:  n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl         = '0;
        lane_ctrl.refresh = r_refresh;
        lane_ctrl.step    = r_step;
        merge_en          = 1'b0;
        unique case (r_state)
            S_PREP_A: lane_ctrl.prep = 1'b1;
            S_MUL_A:  lane_ctrl.mul  = 1'b1;
            S_DIV_A:  lane_ctrl.div  = 1'b1;
            S_PREP_P: begin
                // avg quotient is final here; peak prep runs alongside
                lane_ctrl.prep       = 1'b1;
                lane_ctrl.sel_peak   = 1'b1;
                lane_ctrl.commit_avg = 1'b1;
            end
            S_MUL_P: begin
                lane_ctrl.mul      = 1'b1;
                lane_ctrl.sel_peak = 1'b1;
            end
            S_DIV_P: begin
                lane_ctrl.div      = 1'b1;
                lane_ctrl.sel_peak = 1'b1;
            end
            S_MERGE: begin
                lane_ctrl.commit_peak = 1'b1;
                merge_en              = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL_A || r_state == S_MUL_P) begin
                r_step <= DIV_LAST_STEP;
            end else if (r_state == S_DIV_A || r_state == S_DIV_P) begin
                r_step <= r_step - 3'd1;
            end
        end
    end

    // ---------------- poll capture and time marks ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period  <= SAMPLE_PERIOD_RST;
            r_time_mark_avg  <= '0;
            r_time_mark_peak <= '0;
            r_refresh        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_sample_period <= i_cfg_data;
            end
            if (in_accept) begin
                r_refresh        <= (avg_el >= r_sample_period);
                r_time_mark_peak <= i_in_data.time_now;
                if (avg_el >= r_sample_period) begin
                    r_time_mark_avg <= i_in_data.time_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in      <= i_in_data;
            r_avg_el  <= avg_el;
            r_peak_el <= i_in_data.time_now - r_time_mark_peak;
        end
    end

    // ---------------- lanes ----------------
    for (genvar g = 0; g < MAX_CORES; g++) begin : g_lane
        if (g < CORES) begin : g_on
            cplm_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (lane_ctrl),
                .i_avg_elapsed  (r_avg_el),
                .i_peak_elapsed (r_peak_el),
                .i_idle         (idle[g]),
                .o_load         (lane_load[g]),
                .o_quot         (lane_quot[g])
            );
        end else begin : g_off
            // unpopulated core reads as zero load
            assign lane_load[g] = '0;
            assign lane_quot[g] = '0;
        end
    end

    // ---------------- peak ring ----------------
    cplm_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_merge_en     (merge_en),
        .i_peak         (lane_quot),
        .o_peak_average (peak_average)
    );

    // ---------------- output register ----------------
    always_comb begin
        n_out.load_core0      = lane_load[0];
        n_out.load_core1      = lane_load[1];
        n_out.load_core2      = lane_load[2];
        n_out.load_core3      = lane_load[3];
        n_out.peak_average    = peak_average;
        n_out.loads_refreshed = r_refresh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
